// ===== rtl/twc_pkg.sv =====
`default_nettype none

package twc_pkg;

  localparam int unsigned CMP_W = 21;   // widest component
  localparam int unsigned STG_W = 37;   // stage values, +-(2^36 - 1)
  localparam int unsigned ACC_W = 64;   // sums of products
  localparam int unsigned DN_W  = 25;   // center of mass in world frame, never clamps

  typedef logic signed [CMP_W-1:0] cmp_t;
  typedef logic signed [STG_W-1:0] stg_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [DN_W-1:0]  dnr_t;

  typedef cmp_t  [2:0] cvec_t;
  typedef stg_t  [2:0] svec_t;
  typedef acc_t  [2:0] avec_t;
  typedef cvec_t [2:0] cmat_t;
  typedef svec_t [2:0] smat_t;

  localparam acc_t STG_LIM  = 64'sd68719476735;
  localparam acc_t STG_NLIM = -64'sd68719476735;
  localparam stg_t STG_MAX  = 37'sd68719476735;
  localparam stg_t STG_MIN  = -37'sd68719476735;

  localparam int unsigned FRAC_FT  = 10;
  localparam int unsigned FRAC_ROT = 19;
  localparam int unsigned FRAC_COM = 20;
  localparam int unsigned FRAC_MASS = 10;

  typedef enum logic [2:0] {
    CFG_MASS  = 3'd0,
    CFG_COM   = 3'd1,
    CFG_IDIAG = 3'd2,
    CFG_IOFF  = 3'd3,
    CFG_GRAV  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic c;
    stg_t v;
  } scl_t;

  typedef struct packed {
    logic  c;
    svec_t v;
  } sv3_t;

  typedef struct packed {
    logic  kind;
    cmat_t q;
    cvec_t a;
    cvec_t w;
    cvec_t al;
    svec_t d;
    svec_t fw;
    svec_t tw;
    smat_t ri;
    svec_t fsg;
    svec_t tsg;
    stg_t  d2;
    smat_t dd;
    smat_t rir;
    svec_t ad;
    svec_t wd;
    smat_t par;
    svec_t wwd;
    smat_t is;
    svec_t ac;
    svec_t fsf;
    svec_t ia;
    svec_t iw;
    svec_t gyro;
    svec_t dm;
    svec_t fsub;
    svec_t tsub;
    svec_t df;
    svec_t dt;
    logic  clip_c;
    logic  clip_g;
    logic  clip_f;
  } pipe_t;

  // round half up by 2^s
  function automatic acc_t rnd(acc_t x, int unsigned s);
    acc_t h;
    h = acc_t'(1) <<< (s - 1);
    return (x + h) >>> s;
  endfunction

  function automatic scl_t clp(acc_t x);
    scl_t r;
    r.c = 1'b0;
    r.v = stg_t'(x);
    if (x > STG_LIM) begin
      r.c = 1'b1;
      r.v = STG_MAX;
    end else if (x < STG_NLIM) begin
      r.c = 1'b1;
      r.v = STG_MIN;
    end
    return r;
  endfunction

  function automatic scl_t scl(acc_t x, int unsigned s);
    return clp(rnd(x, s));
  endfunction

  function automatic sv3_t scl3(avec_t x, int unsigned s);
    sv3_t r;
    scl_t t;
    r.c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      t = scl(x[i], s);
      r.v[i] = t.v;
      r.c = r.c | t.c;
    end
    return r;
  endfunction

  function automatic dnr_t dn(stg_t x);
    return x[DN_W-1:0];
  endfunction

  function automatic acc_t mul_sc(stg_t a, cmp_t b);
    logic signed [STG_W+CMP_W-1:0] p;
    p = a * b;
    return acc_t'(p);
  endfunction

  function automatic acc_t mul_sd(stg_t a, dnr_t b);
    logic signed [STG_W+DN_W-1:0] p;
    p = a * b;
    return acc_t'(p);
  endfunction

  function automatic acc_t mul_ms(logic [15:0] m, stg_t b);
    logic signed [16:0] ms;
    logic signed [STG_W+16:0] p;
    ms = {1'b0, m};
    p = ms * b;
    return acc_t'(p);
  endfunction

  function automatic avec_t cross_cs(cvec_t a, svec_t b);
    avec_t o;
    o[0] = mul_sc(b[2], a[1]) - mul_sc(b[1], a[2]);
    o[1] = mul_sc(b[0], a[2]) - mul_sc(b[2], a[0]);
    o[2] = mul_sc(b[1], a[0]) - mul_sc(b[0], a[1]);
    return o;
  endfunction

  function automatic avec_t cross_ds(svec_t a, svec_t b);
    avec_t o;
    o[0] = mul_sd(b[2], dn(a[1])) - mul_sd(b[1], dn(a[2]));
    o[1] = mul_sd(b[0], dn(a[2])) - mul_sd(b[2], dn(a[0]));
    o[2] = mul_sd(b[1], dn(a[0])) - mul_sd(b[0], dn(a[1]));
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tool_wrench_compensation.sv =====
// Tool wrench compensation for a six-axis force/torque sensor.
// Config channel (cfg_valid_i/cfg_ready_o, index + data) loads tool mass,
// center of mass, inertia tensor and gravity; ready is always high and
// writes are expected only while the pipeline is empty.
// Input stream (s_axis): one beat per sensor sample. tuser[0] is the mode
// (0 full inertial, 1 gravity only); tdata carries force, torque, the three
// rotation rows, linear accel, angular velocity and angular accel.
// Output stream (m_axis): compensated force and torque in tdata, clip flag
// in tuser[0]. One result beat per input beat, in order.
// Pipeline: eight compute stages plus the output register. Throughput: one
// beat per cycle while m_axis_tready allows, set by the stage chain; no path
// in a stage holds more than one multiply in series, plus short sums.
// Stalls: every stage has its own valid bit and advances when empty or when
// the stage after it advances, so bubbles close up under backpressure and
// s_axis_tready drops only when all stages and the output hold data.
// Reset clears all valid bits and the config registers to zero.
`default_nettype none

module tool_wrench_compensation
  import twc_pkg::*;
#(
  parameter int unsigned COMPONENT_BITS = 21
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [62:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // force_measured, torque_measured, rotation_row0..2, linear_accel,
  // angular_velocity, angular_accel (63 bits each)
  input  logic [503:0] s_axis_tdata,
  // kind
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // force_compensated, torque_compensated (63 bits each), 2 zero pad bits
  output logic [127:0] m_axis_tdata,
  // saturated
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned NST = 8;
  localparam acc_t OUT_HI = (acc_t'(1) <<< (COMPONENT_BITS - 1)) - acc_t'(1);
  localparam acc_t OUT_LO = -OUT_HI - acc_t'(1);

  // sign-extend x, y, z from the packed word
  function automatic cvec_t unpk(logic [62:0] p);
    cvec_t r;
    for (int i = 0; i < 3; i++) begin
      r[i] = cmp_t'($signed(p[i*COMPONENT_BITS +: COMPONENT_BITS]));
    end
    return r;
  endfunction

  // ---------------- configuration registers ----------------
  logic [15:0] mass_q;
  logic [62:0] com_q, idg_q, iod_q, grav_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= '0;
      com_q  <= '0;
      idg_q  <= '0;
      iod_q  <= '0;
      grav_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MASS:  mass_q <= cfg_data_i[15:0];
        CFG_COM:   com_q  <= cfg_data_i;
        CFG_IDIAG: idg_q  <= cfg_data_i;
        CFG_IOFF:  iod_q  <= cfg_data_i;
        CFG_GRAV:  grav_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic [NST-1:0] v_q;
  logic [NST:0]   en;
  logic           out_v_q;

  always_comb begin
    en[NST] = !out_v_q || m_axis_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
      if (en[NST]) out_v_q <= v_q[NST-1];
    end
  end

  pipe_t st0_d, st1_d, st2_d, st3_d, st4_d, st5_d, st6_d, st7_d;
  pipe_t st0_q, st1_q, st2_q, st3_q, st4_q, st5_q, st6_q, st7_q;

  // stage 0: unpack, rotate measurement and center of mass to world,
  // R*I, gravity force
  always_comb begin
    cvec_t f, t, com, g, dg, od;
    cmat_t qm, ib;
    avec_t ad, af, at;
    acc_t  acc;
    sv3_t  r3;
    scl_t  r1;
    st0_d = '0;
    st0_d.kind = s_axis_tuser[0];
    f   = unpk(s_axis_tdata[62:0]);
    t   = unpk(s_axis_tdata[125:63]);
    qm[0] = unpk(s_axis_tdata[188:126]);
    qm[1] = unpk(s_axis_tdata[251:189]);
    qm[2] = unpk(s_axis_tdata[314:252]);
    st0_d.q  = qm;
    st0_d.a  = unpk(s_axis_tdata[377:315]);
    st0_d.w  = unpk(s_axis_tdata[440:378]);
    st0_d.al = unpk(s_axis_tdata[503:441]);
    com = unpk(com_q);
    g   = unpk(grav_q);
    dg  = unpk(idg_q);
    od  = unpk(iod_q);
    ib[0][0] = dg[0]; ib[1][1] = dg[1]; ib[2][2] = dg[2];
    ib[0][1] = od[0]; ib[1][0] = od[0];
    ib[0][2] = od[1]; ib[2][0] = od[1];
    ib[1][2] = od[2]; ib[2][1] = od[2];
    for (int i = 0; i < 3; i++) begin
      ad[i] = '0;
      af[i] = '0;
      at[i] = '0;
      for (int k = 0; k < 3; k++) begin
        ad[i] = ad[i] + mul_sc(stg_t'(com[k]), qm[k][i]);
        af[i] = af[i] + mul_sc(stg_t'(f[k]), qm[k][i]);
        at[i] = at[i] + mul_sc(stg_t'(t[k]), qm[k][i]);
      end
    end
    r3 = scl3(ad, FRAC_ROT); st0_d.d  = r3.v; st0_d.clip_c = r3.c;
    r3 = scl3(af, FRAC_ROT); st0_d.fw = r3.v; st0_d.clip_c = st0_d.clip_c | r3.c;
    r3 = scl3(at, FRAC_ROT); st0_d.tw = r3.v; st0_d.clip_c = st0_d.clip_c | r3.c;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          acc = acc + mul_sc(stg_t'(ib[k][j]), qm[k][i]);
        end
        r1 = scl(acc, FRAC_ROT);
        st0_d.ri[i][j] = r1.v;
        st0_d.clip_f = st0_d.clip_f | r1.c;
      end
      r1 = scl(mul_ms(mass_q, stg_t'(g[i])), FRAC_MASS);
      st0_d.fsg[i] = r1.v;
      st0_d.clip_g = st0_d.clip_g | r1.c;
    end
  end

  // stage 1: |d|^2, d*d^T, R*I*R^T, alpha x d, w x d, gravity moment
  always_comb begin
    acc_t acc;
    scl_t r1;
    sv3_t r3;
    st1_d = st0_q;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      acc = acc + mul_sd(st0_q.d[k], dn(st0_q.d[k]));
    end
    r1 = scl(acc, FRAC_COM);
    st1_d.d2 = r1.v;
    st1_d.clip_f = st1_d.clip_f | r1.c;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r1 = scl(mul_sd(st0_q.d[i], dn(st0_q.d[j])), FRAC_COM);
        st1_d.dd[i][j] = r1.v;
        st1_d.clip_f = st1_d.clip_f | r1.c;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          acc = acc + mul_sc(st0_q.ri[i][k], st0_q.q[k][j]);
        end
        r1 = scl(acc, FRAC_ROT);
        st1_d.rir[i][j] = r1.v;
        st1_d.clip_f = st1_d.clip_f | r1.c;
      end
    end
    r3 = scl3(cross_cs(st0_q.al, st0_q.d), FRAC_FT);
    st1_d.ad = r3.v; st1_d.clip_f = st1_d.clip_f | r3.c;
    r3 = scl3(cross_cs(st0_q.w, st0_q.d), FRAC_FT);
    st1_d.wd = r3.v; st1_d.clip_f = st1_d.clip_f | r3.c;
    r3 = scl3(cross_ds(st0_q.d, st0_q.fsg), FRAC_COM);
    st1_d.tsg = r3.v; st1_d.clip_g = st1_d.clip_g | r3.c;
  end

  // stage 2: parallel-axis term, w x (w x d)
  always_comb begin
    scl_t inner, r1;
    sv3_t r3;
    acc_t diag;
    st2_d = st1_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        diag  = (i == j) ? acc_t'(st1_q.d2) : '0;
        inner = clp(diag - acc_t'(st1_q.dd[i][j]));
        r1    = scl(mul_ms(mass_q, inner.v), FRAC_MASS);
        st2_d.par[i][j] = r1.v;
        st2_d.clip_f = st2_d.clip_f | inner.c | r1.c;
      end
    end
    r3 = scl3(cross_cs(st1_q.w, st1_q.wd), FRAC_FT);
    st2_d.wwd = r3.v; st2_d.clip_f = st2_d.clip_f | r3.c;
  end

  // stage 3: spatial inertia and center-of-mass acceleration
  always_comb begin
    scl_t r1;
    st3_d = st2_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r1 = clp(acc_t'(st2_q.rir[i][j]) + acc_t'(st2_q.par[i][j]));
        st3_d.is[i][j] = r1.v;
        st3_d.clip_f = st3_d.clip_f | r1.c;
      end
      r1 = clp((acc_t'(st2_q.a[i]) <<< FRAC_FT) + acc_t'(st2_q.ad[i])
               + acc_t'(st2_q.wwd[i]));
      st3_d.ac[i] = r1.v;
      st3_d.clip_f = st3_d.clip_f | r1.c;
    end
  end

  // stage 4: m*a_c, Is*alpha, Is*w
  always_comb begin
    scl_t r1;
    acc_t sa, sw;
    st4_d = st3_q;
    for (int i = 0; i < 3; i++) begin
      r1 = scl(mul_ms(mass_q, st3_q.ac[i]), FRAC_MASS + FRAC_FT);
      st4_d.fsf[i] = r1.v;
      st4_d.clip_f = st4_d.clip_f | r1.c;
      sa = '0;
      sw = '0;
      for (int k = 0; k < 3; k++) begin
        sa = sa + mul_sc(st3_q.is[i][k], st3_q.al[k]);
        sw = sw + mul_sc(st3_q.is[i][k], st3_q.w[k]);
      end
      r1 = scl(sa, FRAC_COM);
      st4_d.ia[i] = r1.v;
      st4_d.clip_f = st4_d.clip_f | r1.c;
      r1 = scl(sw, FRAC_COM);
      st4_d.iw[i] = r1.v;
      st4_d.clip_f = st4_d.clip_f | r1.c;
    end
  end

  // stage 5: gyroscopic term and moment of the inertial force
  always_comb begin
    sv3_t r3;
    st5_d = st4_q;
    r3 = scl3(cross_cs(st4_q.w, st4_q.iw), FRAC_FT);
    st5_d.gyro = r3.v; st5_d.clip_f = st5_d.clip_f | r3.c;
    r3 = scl3(cross_ds(st4_q.d, st4_q.fsf), FRAC_COM);
    st5_d.dm = r3.v; st5_d.clip_f = st5_d.clip_f | r3.c;
  end

  // stage 6: total inertial torque, mode select; only the chosen path's
  // clips count
  always_comb begin
    scl_t r1;
    logic cf;
    st6_d = st5_q;
    cf = st5_q.clip_f;
    for (int i = 0; i < 3; i++) begin
      r1 = clp(acc_t'(st5_q.ia[i]) + acc_t'(st5_q.gyro[i]) + acc_t'(st5_q.dm[i]));
      cf = cf | r1.c;
      st6_d.fsub[i] = st5_q.kind ? st5_q.fsg[i] : st5_q.fsf[i];
      st6_d.tsub[i] = st5_q.kind ? st5_q.tsg[i] : r1.v;
    end
    st6_d.clip_c = st5_q.clip_c | (st5_q.kind ? st5_q.clip_g : cf);
  end

  // stage 7: subtract in world frame
  always_comb begin
    scl_t r1;
    st7_d = st6_q;
    for (int i = 0; i < 3; i++) begin
      r1 = clp(acc_t'(st6_q.fw[i]) - acc_t'(st6_q.fsub[i]));
      st7_d.df[i] = r1.v;
      st7_d.clip_c = st7_d.clip_c | r1.c;
      r1 = clp(acc_t'(st6_q.tw[i]) - acc_t'(st6_q.tsub[i]));
      st7_d.dt[i] = r1.v;
      st7_d.clip_c = st7_d.clip_c | r1.c;
    end
  end

  // output stage: rotate back to sensor frame, saturate to component range
  logic [62:0] out_f_d, out_t_d, out_f_q, out_t_q;
  logic        out_s_d, out_s_q;

  always_comb begin
    acc_t af, at;
    out_f_d = '0;
    out_t_d = '0;
    out_s_d = st7_q.clip_c;
    for (int i = 0; i < 3; i++) begin
      af = '0;
      at = '0;
      for (int k = 0; k < 3; k++) begin
        af = af + mul_sc(st7_q.df[k], st7_q.q[i][k]);
        at = at + mul_sc(st7_q.dt[k], st7_q.q[i][k]);
      end
      af = rnd(af, FRAC_ROT);
      at = rnd(at, FRAC_ROT);
      if (af > OUT_HI) begin
        af = OUT_HI; out_s_d = 1'b1;
      end else if (af < OUT_LO) begin
        af = OUT_LO; out_s_d = 1'b1;
      end
      if (at > OUT_HI) begin
        at = OUT_HI; out_s_d = 1'b1;
      end else if (at < OUT_LO) begin
        at = OUT_LO; out_s_d = 1'b1;
      end
      out_f_d[i*COMPONENT_BITS +: COMPONENT_BITS] = af[COMPONENT_BITS-1:0];
      out_t_d[i*COMPONENT_BITS +: COMPONENT_BITS] = at[COMPONENT_BITS-1:0];
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (en[0]) st0_q <= st0_d;
    if (en[1]) st1_q <= st1_d;
    if (en[2]) st2_q <= st2_d;
    if (en[3]) st3_q <= st3_d;
    if (en[4]) st4_q <= st4_d;
    if (en[5]) st5_q <= st5_d;
    if (en[6]) st6_q <= st6_d;
    if (en[7]) st7_q <= st7_d;
    if (en[NST]) begin
      out_f_q <= out_f_d;
      out_t_q <= out_t_d;
      out_s_q <= out_s_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_t_q, out_f_q};
  assign m_axis_tuser  = out_s_q;

endmodule

`default_nettype wire

// ===== tb/tool_wrench_compensation_chk.sv =====
`timescale 1ns / 100ps

module tool_wrench_compensation_chk
  import twc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [62:0]  cfg_data_i,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [503:0] s_data_i,
  input  logic [0:0]   s_user_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [127:0] m_data_i,
  input  logic [0:0]   m_user_i,
  output int           errors_o,
  output int           pending_o,
  output int           checked_o
);

  typedef longint vec_t [3];
  typedef longint mat_t [3][3];
  typedef struct {
    logic [62:0] force_c;
    logic [62:0] torque_c;
    logic        sat;
  } wrench_t;

  localparam longint LIM = 64'sd68719476735;

  logic [15:0] mass_q;
  logic [62:0] com_q, idiag_q, ioff_q, grav_q;
  bit          clip_hit;
  wrench_t     wrench_q[$];

  function automatic longint comp(logic [62:0] p, int i);
    logic signed [20:0] u;
    u = p[i*21 +: 21];
    return longint'(u);
  endfunction

  function automatic vec_t unpk(logic [62:0] p);
    vec_t v;
    for (int i = 0; i < 3; i++) v[i] = comp(p, i);
    return v;
  endfunction

  function automatic longint stg(longint x);
    if (x > LIM) begin
      clip_hit = 1'b1;
      return LIM;
    end
    if (x < -LIM) begin
      clip_hit = 1'b1;
      return -LIM;
    end
    return x;
  endfunction

  function automatic longint scl(longint x, int s);
    return stg((x + (64'sd1 <<< (s - 1))) >>> s);
  endfunction

  function automatic vec_t mv(mat_t m, vec_t v, int s);
    vec_t o;
    for (int i = 0; i < 3; i++) o[i] = scl(m[i][0]*v[0] + m[i][1]*v[1] + m[i][2]*v[2], s);
    return o;
  endfunction

  function automatic vec_t xp(vec_t a, vec_t b, int s);
    vec_t o;
    o[0] = scl(a[1]*b[2] - a[2]*b[1], s);
    o[1] = scl(a[2]*b[0] - a[0]*b[2], s);
    o[2] = scl(a[0]*b[1] - a[1]*b[0], s);
    return o;
  endfunction

  // rotate back to sensor frame, clamp to 21-bit components
  function automatic logic [62:0] to_sensor(mat_t q, vec_t v);
    logic [62:0] r;
    longint      c;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      c = (q[i][0]*v[0] + q[i][1]*v[1] + q[i][2]*v[2] + (64'sd1 <<< 18)) >>> 19;
      if (c > 1048575) begin
        c = 1048575;
        clip_hit = 1'b1;
      end else if (c < -1048576) begin
        c = -1048576;
        clip_hit = 1'b1;
      end
      r[i*21 +: 21] = c[20:0];
    end
    return r;
  endfunction

  function automatic wrench_t compensate(logic kind, logic [503:0] dat);
    mat_t    q, r, ib, ri, is;
    vec_t    f, t, d, fw, tw, fs, ts, g, a, w, al, dg, od;
    vec_t    ad, wd, wwd, ia, iw, gy, dm, df, dt;
    longint  m, d2, acc, dd, inner, par;
    wrench_t res;
    clip_hit = 1'b0;
    m = longint'(mass_q);
    for (int i = 0; i < 3; i++) begin
      q[i] = unpk(dat[126 + 63*i +: 63]);
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) r[i][j] = q[j][i];
    f = unpk(dat[62:0]);
    t = unpk(dat[125:63]);
    d  = mv(r, unpk(com_q), 19);
    fw = mv(r, f, 19);
    tw = mv(r, t, 19);
    if (kind) begin
      g = unpk(grav_q);
      for (int i = 0; i < 3; i++) fs[i] = scl(m * g[i], 10);
      ts = xp(d, fs, 20);
    end else begin
      a  = unpk(dat[377:315]);
      w  = unpk(dat[440:378]);
      al = unpk(dat[503:441]);
      dg = unpk(idiag_q);
      od = unpk(ioff_q);
      ib[0][0] = dg[0]; ib[1][1] = dg[1]; ib[2][2] = dg[2];
      ib[0][1] = od[0]; ib[1][0] = od[0];
      ib[0][2] = od[1]; ib[2][0] = od[1];
      ib[1][2] = od[2]; ib[2][1] = od[2];
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          ri[i][j] = scl(r[i][0]*ib[0][j] + r[i][1]*ib[1][j] + r[i][2]*ib[2][j], 19);
      d2 = scl(d[0]*d[0] + d[1]*d[1] + d[2]*d[2], 20);
      // parallel-axis inertia in world frame
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = ri[i][0]*r[j][0] + ri[i][1]*r[j][1] + ri[i][2]*r[j][2];
          dd = scl(d[i]*d[j], 20);
          inner = stg((i == j ? d2 : 0) - dd);
          par = scl(m * inner, 10);
          is[i][j] = stg(scl(acc, 19) + par);
        end
      ad  = xp(al, d, 10);
      wd  = xp(w, d, 10);
      wwd = xp(w, wd, 10);
      for (int i = 0; i < 3; i++) fs[i] = scl(m * stg(a[i]*1024 + ad[i] + wwd[i]), 20);
      ia = mv(is, al, 20);
      iw = mv(is, w, 20);
      gy = xp(w, iw, 10);
      dm = xp(d, fs, 20);
      for (int i = 0; i < 3; i++) ts[i] = stg(ia[i] + gy[i] + dm[i]);
    end
    for (int i = 0; i < 3; i++) begin
      df[i] = stg(fw[i] - fs[i]);
      dt[i] = stg(tw[i] - ts[i]);
    end
    res.force_c  = to_sensor(q, df);
    res.torque_c = to_sensor(q, dt);
    res.sat      = clip_hit;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wrench_t e;
    int      n_err;
    n_err = 0;
    if (!rst_ni) begin
      mass_q <= '0; com_q <= '0; idiag_q <= '0; ioff_q <= '0; grav_q <= '0;
      errors_o <= 0;
      checked_o <= 0;
      wrench_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MASS:  mass_q  <= cfg_data_i[15:0];
          CFG_COM:   com_q   <= cfg_data_i;
          CFG_IDIAG: idiag_q <= cfg_data_i;
          CFG_IOFF:  ioff_q  <= cfg_data_i;
          CFG_GRAV:  grav_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) wrench_q.push_back(compensate(s_user_i[0], s_data_i));
      if (m_valid_i && m_ready_i) begin
        if (wrench_q.size() == 0) begin
          $error("result beat with no expectation pending");
          n_err++;
        end else begin
          e = wrench_q.pop_front();
          checked_o <= checked_o + 1;
          if (m_data_i[62:0] !== e.force_c) begin
            $error("force_compensated: expected %h, got %h", e.force_c, m_data_i[62:0]);
            n_err++;
          end
          if (m_data_i[125:63] !== e.torque_c) begin
            $error("torque_compensated: expected %h, got %h", e.torque_c, m_data_i[125:63]);
            n_err++;
          end
          if (m_user_i[0] !== e.sat) begin
            $error("saturated: expected %b, got %b", e.sat, m_user_i[0]);
            n_err++;
          end
        end
      end
      if (n_err != 0) errors_o <= errors_o + n_err;
    end
  end

  assign pending_o = wrench_q.size();

endmodule

// ===== tb/tool_wrench_compensation_tb.sv =====
`timescale 1ns / 100ps

module tool_wrench_compensation_tb;
  import twc_pkg::*;

  localparam int IDLE_LIMIT = 3000;  // cycles with no beat on any channel
  localparam int ONE = 1 << 19;      // 1.0 in rotation format

  logic         clk, rst_n;
  logic         cfg_valid, cfg_ready;
  logic [2:0]   cfg_index;
  logic [62:0]  cfg_data;
  logic         s_valid, s_ready;
  logic [503:0] s_data;  // force, torque, row0..2, lin accel, ang vel, ang accel
  logic [0:0]   s_user;  // kind
  logic         m_valid, m_ready;
  logic [127:0] m_data;  // force_comp, torque_comp, pad
  logic [0:0]   m_user;  // saturated
  int           errors, pending, checked;
  int           sent, burst_left;
  bit           long_hold;

  tool_wrench_compensation dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tuser(m_user)
  );

  tool_wrench_compensation_chk chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data), .s_user_i(s_user),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data), .m_user_i(m_user),
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: no beat anywhere for too long means a hang
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: stall pattern steps through four settings; one long hold on request
  initial begin
    int cyc;
    cyc = 0;
    m_ready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (long_hold) begin
        m_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        case ((cyc / 64) % 4)
          0: m_ready <= 1'b1;
          1: m_ready <= ($urandom_range(0, 1) == 0);
          2: m_ready <= ($urandom_range(0, 3) == 0);
          default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic logic [62:0] pk(int x, int y, int z);
    return {z[20:0], y[20:0], x[20:0]};
  endfunction

  // random component of random magnitude, both signs
  function automatic int rcomp();
    int k, v;
    k = $urandom_range(1, 21);
    v = $urandom & ((1 << k) - 1);
    if (v[k-1]) v = v - (1 << k);
    return v;
  endfunction

  function automatic logic [62:0] rvec();
    return pk(rcomp(), rcomp(), rcomp());
  endfunction

  function automatic logic [62:0] rwide();
    return {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF;
  endfunction

  // mostly signed permutation matrices with a little noise, sometimes junk
  function automatic logic [188:0] rrot();
    int p[3];
    int e[3][3];
    int s;
    if ($urandom_range(0, 3) == 0) return {rwide(), rwide(), rwide()};
    p = '{0, 1, 2};
    s = $urandom_range(0, 2);
    p = '{(s) % 3, (s + 1) % 3, (s + 2) % 3};
    if ($urandom_range(0, 1)) begin
      s = p[1]; p[1] = p[2]; p[2] = s;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        e[i][j] = (j == p[i]) ? ($urandom_range(0, 1) ? ONE : -ONE) : 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        e[i][j] += $urandom_range(0, 2047) - 1024;
    return {pk(e[2][0], e[2][1], e[2][2]), pk(e[1][0], e[1][1], e[1][2]),
            pk(e[0][0], e[0][1], e[0][2])};
  endfunction

  task automatic cfg_write(cfg_idx_e idx, logic [62:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic config_all(logic [15:0] m, logic [62:0] c, logic [62:0] di,
                            logic [62:0] od, logic [62:0] g);
    cfg_write(CFG_MASS, {47'd0, m});
    cfg_write(CFG_COM, c);
    cfg_write(CFG_IDIAG, di);
    cfg_write(CFG_IOFF, od);
    cfg_write(CFG_GRAV, g);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);  // pipeline depth plus margin
  endtask

  // one input beat; valid stays high across a burst
  task automatic send(logic kind, logic [503:0] dat);
    int gap;
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= dat;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic send_directed();
    logic [188:0] ident;
    ident = {pk(0, 0, ONE), pk(0, ONE, 0), pk(ONE, 0, 0)};
    send(1'b0, '0);
    send(1'b1, '0);
    send(1'b1, {{3{63'd0}}, ident, pk(-1048576, -1048576, -1048576),
                pk(1048575, 1048575, 1048575)});
    send(1'b0, {{3{pk(1048575, 1048575, 1048575)}}, ident,
                pk(1, -1, 512), pk(-1024, 1024, 0)});
    send(1'b0, {8{63'h7FFF_FFFF_FFFF_FFFF}});
    send(1'b1, {8{63'h7FFF_FFFF_FFFF_FFFF}});
    send(1'b0, {8{pk(1048575, 1048575, 1048575)}});
    send(1'b0, {8{pk(-1048576, -1048576, -1048576)}});
    send(1'b1, {8{pk(-1048576, -1048576, -1048576)}});
    send(1'b1, {rwide(), rwide(), rwide(), rwide(), rwide(), rwide(), rwide(), rwide()});
    send(1'b0, {rvec(), rvec(), rvec(), ident, rvec(), rvec()});
  endtask

  task automatic send_random(int n, bit hold, bit pause);
    logic kind;
    for (int i = 0; i < n; i++) begin
      if (hold && i == n / 3) long_hold = 1'b1;
      if (pause && i == n / 2) begin
        s_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0)
        send(kind, {rwide(), rwide(), rwide(), rwide(), rwide(), rwide(), rwide(), rwide()});
      else
        send(kind, {rvec(), rvec(), rvec(), rrot(), rvec(), rvec()});
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    s_valid = 1'b0; s_data = '0; s_user = '0;
    long_hold = 1'b0;
    sent = 0;
    burst_left = $urandom_range(1, 40);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config (all zero), then a plausible tool
    send_directed();
    s_valid <= 1'b0;
    drain();
    config_all(16'd2048, pk(0, 20000, 100000), pk(10000, 12000, 4000),
               pk(-500, 300, 200), pk(0, 0, -10045));
    send_directed();
    send_random(350, 1'b1, 1'b0);
    s_valid <= 1'b0;
    drain();

    // extremes: maximum mass and positive components, inertia diagonal all ones
    config_all(16'hFFFF, pk(1048575, 1048575, 1048575), 63'h7FFF_FFFF_FFFF_FFFF,
               pk(1048575, 1048575, 1048575), pk(1048575, 1048575, 1048575));
    send_random(350, 1'b0, 1'b1);
    s_valid <= 1'b0;
    drain();

    // most negative components
    config_all(16'h0001, pk(-1048576, -1048576, -1048576), pk(-1048576, -1048576, -1048576),
               pk(-1048576, -1048576, -1048576), pk(-1048576, -1048576, -1048576));
    send_random(300, 1'b0, 1'b0);
    s_valid <= 1'b0;
    drain();

    // random registers
    config_all($urandom, rvec(), rvec(), rvec(), rvec());
    send_random(380, 1'b0, 1'b0);
    s_valid <= 1'b0;
    drain();

    $display("Sent %0d sample beats over five register settings, checked %0d results,",
             sent, checked);
    $display("both modes, saturating and non-orthonormal cases, under stalls and gaps.");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/twc_pkg.sv
rtl/tool_wrench_compensation.sv
tb/tool_wrench_compensation_chk.sv
tb/tool_wrench_compensation_tb.sv
